[rtl/asms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asms_pkg
// Types, constants and the drive command table of the stroke motor sequencer.
// ----------------------------------------------------------------------------
package asms_pkg;

    localparam int POS_W    = 18;
    localparam int TIME_W   = 32;
    localparam int VEL_W    = 18;
    localparam int DRIVE_W  = 14;
    localparam int OUT_DRV_W = 15;
    localparam int CNT_W    = 16;
    localparam int LIM_W    = 17;
    localparam int WANT_W   = 7;
    localparam int CTRL_W   = 8;
    localparam int CMP_W    = 19;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [LIM_W-1:0]   LIMIT_LOW    = 17'd50;
    localparam logic [LIM_W-1:0]   LIMIT_HIGH   = 17'd17000;
    localparam logic [CMP_W-1:0]   LIMIT_OFFSET = 19'd50;
    localparam logic [15:0]        SPEED_RECIP  = 16'd62138;
    localparam int                 SPEED_SHIFT  = 25;
    localparam logic [DRIVE_W-1:0] DRIVE_CAP    = 14'd9830;
    localparam logic [CTRL_W-1:0]  DRIVE_BIAS   = 8'd7;
    localparam logic [15:0]        DRIVE_KNEE   = 16'd30;

    typedef enum logic [1:0] {
        PH_WAIT_FWD  = 2'd0,
        PH_PUSH_FWD  = 2'd1,
        PH_WAIT_BACK = 2'd2,
        PH_PUSH_BACK = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_VEL,
        ST_MGO,
        ST_MEAN,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        REG_START_POS = 2'd0,
        REG_END_POS   = 2'd1,
        REG_REP_TGT   = 2'd2,
        REG_DES_SPEED = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    sample_due;
        logic [TIME_W-1:0]       timestamp_ms;
    } t_in;

    typedef struct packed {
        logic signed [OUT_DRV_W-1:0] motor_drive;
        logic [1:0]                  phase;
        logic [CNT_W-1:0]            repetitions;
        logic                        done_res;
    } t_out;

    // drive command for a control value: value * 32768 / 100, capped
    function automatic logic [DRIVE_W-1:0] drive_cmd(input logic [15:0] raw);
        logic [DRIVE_W-1:0] v;
        if (raw >= DRIVE_KNEE) begin
            v = DRIVE_CAP;
        end else begin
            case (raw[4:0])
                5'd0:    v = 14'd0;
                5'd1:    v = 14'd327;
                5'd2:    v = 14'd655;
                5'd3:    v = 14'd983;
                5'd4:    v = 14'd1310;
                5'd5:    v = 14'd1638;
                5'd6:    v = 14'd1966;
                5'd7:    v = 14'd2293;
                5'd8:    v = 14'd2621;
                5'd9:    v = 14'd2949;
                5'd10:   v = 14'd3276;
                5'd11:   v = 14'd3604;
                5'd12:   v = 14'd3932;
                5'd13:   v = 14'd4259;
                5'd14:   v = 14'd4587;
                5'd15:   v = 14'd4915;
                5'd16:   v = 14'd5242;
                5'd17:   v = 14'd5570;
                5'd18:   v = 14'd5898;
                5'd19:   v = 14'd6225;
                5'd20:   v = 14'd6553;
                5'd21:   v = 14'd6881;
                5'd22:   v = 14'd7208;
                5'd23:   v = 14'd7536;
                5'd24:   v = 14'd7864;
                5'd25:   v = 14'd8192;
                5'd26:   v = 14'd8519;
                5'd27:   v = 14'd8847;
                5'd28:   v = 14'd9175;
                5'd29:   v = 14'd9502;
                default: v = DRIVE_CAP;
            endcase
        end
        return v;
    endfunction

endpackage

[rtl/asms_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asms_serial_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module asms_serial_div
    import asms_pkg::*;
#(
    parameter int DIVIDEND_W = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [TIME_W-1:0]     i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [TIME_W-1:0]     r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [TIME_W-1:0]     r_dvs, n_dvs;
    logic [TIME_W:0]       trial;
    logic                  fits;

    always_comb begin
        trial  = {r_rem, r_quo[DIVIDEND_W-1]};
        fits   = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(DIVIDEND_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? TIME_W'(trial - {1'b0, r_dvs}) : trial[TIME_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/assistive_stroke_motor_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assistive_stroke_motor_sequencer_unit
// Four-phase stroke sequencer with speed-regulated drive level.
// ----------------------------------------------------------------------------
// One input item per control tick (position, sample flag, timestamp) on the
// in channel; one result item per tick on the out channel. Both channels use
// valid/stall; an item moves when valid is high and stall is low.
// Configuration goes through the APB-style port; write it only while idle.
// A tick without a velocity sample goes from the accept state via the finish
// state into the output register. A sample runs the bit-serial divider
// once for the velocity; once the window is full a second pass divides the
// window sum for the mean. The next item is accepted as soon as the previous
// one has left for the output register, even while that result is still
// stalled; a finished item waits in its last state until the output
// register frees up.
// Reset restores the register defaults, clears the sequencer, the stroke
// count, the speed window and done; the first item after reset seeds the
// velocity reference.
// ----------------------------------------------------------------------------
module assistive_stroke_motor_sequencer_unit
    import asms_pkg::*;
#(
    parameter int WINDOW_LEN = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = VEL_W + $clog2(WINDOW_LEN);

    t_state                  r_state, n_state;
    logic [LIM_W-1:0]        r_start, n_start;
    logic [LIM_W-1:0]        r_end, n_end;
    logic [CNT_W-1:0]        r_target, n_target;
    logic [15:0]             r_desired, n_desired;
    logic [WANT_W-1:0]       r_want;
    t_phase                  r_phase, n_phase;
    logic [DRIVE_W-1:0]      r_drive, n_drive;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_done, n_done;
    logic                    r_seeded, n_seeded;
    logic signed [POS_W-1:0] r_last_pos, n_last_pos;
    logic [TIME_W-1:0]       r_last_time, n_last_time;
    logic [VEL_W-1:0]        r_win [WINDOW_LEN];
    logic [VEL_W-1:0]        n_win [WINDOW_LEN];
    logic [IDX_W-1:0]        r_wpos, n_wpos;
    logic                    r_full, n_full;
    logic [SUM_W-1:0]        r_sum, n_sum;
    logic [VEL_W-1:0]        r_mean, n_mean;
    logic signed [CMP_W-1:0] r_dp, n_dp;
    logic [TIME_W-1:0]       r_dt, n_dt;
    logic                    r_act, n_act;
    t_out                    r_res, n_res;
    t_out                    r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    cfg_wr;
    logic                    out_free;
    logic                    div_start;
    logic [SUM_W-1:0]        div_dividend;
    logic [TIME_W-1:0]       div_divisor;
    logic                    div_busy;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quo;
    logic [31:0]             want_prod;

    logic signed [CMP_W-1:0] pos_x, min_lim, max_lim, fwd_lim, back_lim;
    logic signed [OUT_DRV_W-1:0] drv_out;
    logic [CNT_W-1:0]        cnt_new;
    logic                    done_new;
    logic [VEL_W-1:0]        dp_mag;
    logic [TIME_W-1:0]       dt_mag;
    logic [VEL_W-1:0]        vel;
    logic [CTRL_W-1:0]       ctrl;

    asms_serial_div #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign cfg_wr    = psel && penable && pwrite;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign want_prod = r_desired * SPEED_RECIP;

    // stroke limits
    always_comb begin
        pos_x    = CMP_W'(i_in_data.position);
        min_lim  = $signed({2'b00, (r_start < LIMIT_LOW) ? LIMIT_LOW : r_start});
        max_lim  = $signed({2'b00, (r_end > LIMIT_HIGH) ? LIMIT_HIGH : r_end});
        fwd_lim  = min_lim + $signed(LIMIT_OFFSET);
        back_lim = max_lim - $signed(LIMIT_OFFSET);
        dp_mag   = r_dp[CMP_W-1] ? VEL_W'(-r_dp) : VEL_W'(r_dp);
        dt_mag   = r_dt[TIME_W-1] ? -r_dt : r_dt;
        vel      = (r_dt == '0) ? '0 : div_quo[VEL_W-1:0];
        ctrl     = CTRL_W'(r_want) - CTRL_W'(r_mean[WANT_W-1:0]) + DRIVE_BIAS;
    end

    always_comb begin
        n_state     = r_state;
        n_start     = r_start;
        n_end       = r_end;
        n_target    = r_target;
        n_desired   = r_desired;
        n_phase     = r_phase;
        n_drive     = r_drive;
        n_count     = r_count;
        n_done      = r_done;
        n_seeded    = r_seeded;
        n_last_pos  = r_last_pos;
        n_last_time = r_last_time;
        n_win       = r_win;
        n_wpos      = r_wpos;
        n_full      = r_full;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_dp        = r_dp;
        n_dt        = r_dt;
        n_act       = r_act;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        div_start   = 1'b0;
        div_dividend = SUM_W'(dp_mag);
        div_divisor  = dt_mag;
        drv_out     = '0;
        cnt_new     = r_count;
        done_new    = r_done;

        if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_START_POS: n_start  = pwdata[LIM_W-1:0];
                REG_END_POS:   n_end    = pwdata[LIM_W-1:0];
                REG_REP_TGT:   n_target = pwdata[CNT_W-1:0];
                REG_DES_SPEED: begin
                    n_desired = pwdata[15:0];
                    n_drive   = drive_cmd(pwdata[15:0]);
                end
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_act   = !r_done;
                    n_state = ST_FIN;
                    if (!r_done) begin
                        unique case (r_phase)
                            PH_WAIT_FWD: begin
                                if (pos_x >= fwd_lim) n_phase = PH_PUSH_FWD;
                            end
                            PH_PUSH_FWD: begin
                                drv_out = $signed({1'b0, r_drive});
                                if (pos_x <= min_lim) n_phase = PH_WAIT_FWD;
                                else if (pos_x >= max_lim) n_phase = PH_WAIT_BACK;
                            end
                            PH_WAIT_BACK: begin
                                if (pos_x <= back_lim) n_phase = PH_PUSH_BACK;
                            end
                            PH_PUSH_BACK: begin
                                drv_out = -$signed({1'b0, r_drive});
                                if (pos_x >= max_lim) begin
                                    n_phase = PH_WAIT_BACK;
                                end else if (pos_x <= min_lim) begin
                                    n_phase = PH_WAIT_FWD;
                                    if (r_count != '1) cnt_new = r_count + 1'b1;
                                end
                            end
                        endcase
                        done_new = cnt_new >= r_target;
                        if (done_new) drv_out = '0;
                        n_count = cnt_new;
                        n_done  = done_new;
                        if (!r_seeded) begin
                            n_seeded    = 1'b1;
                            n_last_pos  = i_in_data.position;
                            n_last_time = i_in_data.timestamp_ms;
                        end else if (i_in_data.sample_due) begin
                            n_dp        = pos_x - CMP_W'(r_last_pos);
                            n_dt        = i_in_data.timestamp_ms - r_last_time;
                            n_last_pos  = i_in_data.position;
                            n_last_time = i_in_data.timestamp_ms;
                            n_state     = ST_PREP;
                        end
                    end
                    n_res.motor_drive = drv_out;
                    n_res.phase       = r_phase;
                    n_res.repetitions = cnt_new;
                    n_res.done_res    = done_new;
                end
            end
            ST_PREP: begin
                div_start = 1'b1;
                n_state   = ST_VEL;
            end
            ST_VEL: begin
                if (div_done) begin
                    n_win[r_wpos] = vel;
                    n_sum = r_sum - SUM_W'(r_win[r_wpos]) + SUM_W'(vel);
                    if (r_wpos == IDX_W'(WINDOW_LEN - 1)) begin
                        n_wpos = '0;
                        n_full = 1'b1;
                    end else begin
                        n_wpos = r_wpos + 1'b1;
                    end
                    n_state = (r_full || r_wpos == IDX_W'(WINDOW_LEN - 1)) ? ST_MGO : ST_FIN;
                end
            end
            ST_MGO: begin
                div_start    = 1'b1;
                div_dividend = r_sum;
                div_divisor  = TIME_W'(WINDOW_LEN);
                n_state      = ST_MEAN;
            end
            ST_MEAN: begin
                if (div_done) begin
                    n_mean  = div_quo[VEL_W-1:0];
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_act && r_full) begin
                        n_drive = (r_mean < VEL_W'(r_want)) ? drive_cmd(16'(ctrl)) : '0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= LIMIT_LOW;
            r_end       <= LIMIT_HIGH;
            r_target    <= 16'd10;
            r_desired   <= '0;
            r_want      <= '0;
            r_phase     <= PH_WAIT_FWD;
            r_drive     <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_seeded    <= 1'b0;
            r_wpos      <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_end       <= n_end;
            r_target    <= n_target;
            r_desired   <= n_desired;
            r_want      <= want_prod[SPEED_SHIFT +: WANT_W];
            r_phase     <= n_phase;
            r_drive     <= n_drive;
            r_count     <= n_count;
            r_done      <= n_done;
            r_seeded    <= n_seeded;
            r_wpos      <= n_wpos;
            r_full      <= n_full;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            r_win       <= n_win;
        end
        r_last_pos  <= n_last_pos;
        r_last_time <= n_last_time;
        r_mean      <= n_mean;
        r_dp        <= n_dp;
        r_dt        <= n_dt;
        r_act       <= n_act;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // register readback
    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_START_POS: prdata = DATA_W'(r_start);
            REG_END_POS:   prdata = DATA_W'(r_end);
            REG_REP_TGT:   prdata = DATA_W'(r_target);
            REG_DES_SPEED: prdata = DATA_W'(r_desired);
        endcase
    end

    assign pready      = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_done_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.motor_drive == '0)
        else $error("drive nonzero on a done item");

    a_frozen_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && $past(r_done) |-> $stable(r_phase) && $stable(r_count))
        else $error("sequencer moved after done");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_drive_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive <= DRIVE_CAP)
        else $error("drive level above cap");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the stroke motor sequencer against a cycle-free predictor.
// ----------------------------------------------------------------------------
// A directed walk covers the stroke phases, the position extremes and the
// velocity corner cases. Random stroke sweeps mixed with noise ticks then run
// under several limit and speed settings. These include crossed, clamped and
// narrow limits, and a long hold on the result side that fills the block.
// A last part reaches the repetition target and checks that done holds.
// Every result is compared field by field with the predicted tick.
// ----------------------------------------------------------------------------
module testbench;
    import asms_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam longint CYCLE_LIMIT   = 1500000;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     HIST_LEN      = 5;
    localparam int     BURST_CYCLES  = 400;
    localparam int     POS_MAX       = 131071;
    localparam int     POS_MIN       = -131072;
    localparam int     SPEED_DIV     = 540;
    localparam longint DRIVE_NUM     = 32768;
    localparam longint DRIVE_DEN     = 100;
    localparam int     REPORT_LINES  = 40;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    assistive_stroke_motor_sequencer_unit #(
        .WINDOW_LEN(HIST_LEN)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor state and register copies
    t_phase             seq_phase;
    logic [DRIVE_W-1:0] drive_mag;
    logic [CNT_W-1:0]   strokes_done;
    logic [VEL_W-1:0]   vel_hist [HIST_LEN];
    int                 vel_fill;
    int                 vel_wr;
    int                 ref_pos;
    logic [TIME_W-1:0]  ref_ms;
    bit                 ref_valid;
    bit                 run_done;
    logic [LIM_W-1:0]   cfg_start;
    logic [LIM_W-1:0]   cfg_end;
    logic [CNT_W-1:0]   cfg_target;
    logic [CNT_W-1:0]   cfg_speed;

    t_out   expected_ticks[$];
    t_out   due_tick;
    int     ticks_sent      = 0;
    int     results_checked = 0;
    int     samples_logged  = 0;
    int     mismatches      = 0;
    longint cycle_count     = 0;

    // stimulus state
    int          sw_pos       = 0;
    bit          sw_up        = 1'b1;
    logic [31:0] sw_ms        = 32'd5000;
    int          t_scale      = 1;
    int          quiet_left   = 0;
    bit          sender_eager = 1'b0;
    int          burst_num    = 0;
    int          burst_seen   = 0;
    int          burst_left   = 0;
    int          run_left     = 0;

    function automatic logic [DRIVE_W-1:0] capped_level(input longint v);
        return (v > longint'(DRIVE_CAP)) ? DRIVE_CAP : DRIVE_W'(v);
    endfunction

    function automatic int lower_limit();
        return (cfg_start < LIMIT_LOW) ? int'(LIMIT_LOW) : int'(cfg_start);
    endfunction

    function automatic int upper_limit();
        return (cfg_end > LIMIT_HIGH) ? int'(LIMIT_HIGH) : int'(cfg_end);
    endfunction

    function automatic void clear_model();
        cfg_start    = LIMIT_LOW;
        cfg_end      = LIMIT_HIGH;
        cfg_target   = 16'd10;
        cfg_speed    = '0;
        seq_phase    = PH_WAIT_FWD;
        drive_mag    = capped_level(0);
        strokes_done = '0;
        foreach (vel_hist[k]) vel_hist[k] = '0;
        vel_fill     = 0;
        vel_wr       = 0;
        ref_pos      = 0;
        ref_ms       = '0;
        ref_valid    = 1'b0;
        run_done     = 1'b0;
    endfunction

    function automatic t_out predict_tick(input t_in item);
        t_out              res;
        int                pos;
        int                lo;
        int                hi;
        int                drv;
        int                sum;
        int                mean;
        int                want;
        logic [TIME_W-1:0] du;
        longint            dt;
        longint            dp;
        longint            vel;
        t_phase            acting;
        pos    = $signed(item.position);
        acting = seq_phase;
        drv    = 0;
        if (!run_done) begin
            lo = lower_limit();
            hi = upper_limit();
            case (seq_phase)
                PH_WAIT_FWD: begin
                    if (pos >= lo + int'(LIMIT_OFFSET)) seq_phase = PH_PUSH_FWD;
                end
                PH_PUSH_FWD: begin
                    drv = int'(drive_mag);
                    if (pos <= lo) seq_phase = PH_WAIT_FWD;
                    else if (pos >= hi) seq_phase = PH_WAIT_BACK;
                end
                PH_WAIT_BACK: begin
                    if (pos <= hi - int'(LIMIT_OFFSET)) seq_phase = PH_PUSH_BACK;
                end
                default: begin
                    drv = -int'(drive_mag);
                    if (pos >= hi) begin
                        seq_phase = PH_WAIT_BACK;
                    end else if (pos <= lo) begin
                        seq_phase = PH_WAIT_FWD;
                        if (strokes_done != '1) strokes_done++;
                    end
                end
            endcase

            // first tick only seeds the velocity reference
            if (!ref_valid) begin
                ref_valid = 1'b1;
                ref_pos   = pos;
                ref_ms    = item.timestamp_ms;
            end else if (item.sample_due) begin
                du  = item.timestamp_ms - ref_ms;
                dt  = longint'($signed(du));
                dp  = longint'(pos) - longint'(ref_pos);
                vel = (dt != 0) ? dp / dt : 0;
                if (vel < 0) vel = -vel;
                vel_hist[vel_wr] = vel[VEL_W-1:0];
                vel_wr = (vel_wr + 1) % HIST_LEN;
                if (vel_fill < HIST_LEN) vel_fill++;
                samples_logged++;
                ref_pos = pos;
                ref_ms  = item.timestamp_ms;
            end

            if (vel_fill >= HIST_LEN) begin
                sum = 0;
                foreach (vel_hist[k]) sum += int'(vel_hist[k]);
                mean = sum / HIST_LEN;
                want = int'(cfg_speed) / SPEED_DIV;
                if (mean < want) begin
                    drive_mag = capped_level(longint'(want - mean + int'(DRIVE_BIAS))
                                             * DRIVE_NUM / DRIVE_DEN);
                end else begin
                    drive_mag = '0;
                end
            end

            if (strokes_done >= cfg_target) begin
                run_done = 1'b1;
                drv      = 0;
            end
        end
        res.motor_drive = drv[OUT_DRV_W-1:0];
        res.phase       = acting;
        res.repetitions = strokes_done;
        res.done_res    = run_done;
        return res;
    endfunction

    function automatic t_in tick(input int pos, input bit due, input logic [31:0] ms);
        t_in item;
        item.position     = pos[POS_W-1:0];
        item.sample_due   = due;
        item.timestamp_ms = ms;
        return item;
    endfunction

    // position sweeping back and forth across the stroke limits
    function automatic t_in stroke_tick();
        t_in item;
        int  lo_s;
        int  hi_s;
        int  step;
        lo_s = lower_limit();
        hi_s = upper_limit();
        if (lo_s > hi_s) begin
            step = lo_s;
            lo_s = hi_s;
            hi_s = step;
        end
        step   = int'($urandom_range((hi_s - lo_s) / 6 + 40, 0));
        sw_pos = sw_up ? sw_pos + step : sw_pos - step;
        if (sw_pos > POS_MAX) sw_pos = POS_MAX;
        if (sw_pos < POS_MIN) sw_pos = POS_MIN;
        if (sw_up && (sw_pos >= hi_s + int'($urandom_range(150, 0)) || sw_pos == POS_MAX)) begin
            sw_up = 1'b0;
        end else if (!sw_up && sw_pos <= lo_s - int'($urandom_range(150, 0))) begin
            sw_up = 1'b1;
        end
        sw_ms = sw_ms + $urandom_range(40, 0) * t_scale;
        item.position     = sw_pos[POS_W-1:0];
        item.sample_due   = 1'($urandom_range(1, 0));
        item.timestamp_ms = sw_ms;
        return item;
    endfunction

    function automatic t_in noise_tick();
        t_in item;
        item.position     = POS_W'($urandom());
        item.sample_due   = 1'($urandom_range(1, 0));
        item.timestamp_ms = $urandom();
        return item;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= REPORT_LINES) begin
            $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
    endtask

    task automatic send_tick(input t_in item);
        int gap;
        int roll;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_ticks.push_back(predict_tick(item));
        ticks_sent++;
        gap = 0;
        if (quiet_left != 0) begin
            quiet_left--;
        end else if (!sender_eager) begin
            roll = $urandom_range(99, 0);
            if (roll < 3) quiet_left = $urandom_range(60, 20);
            else if (roll < 55) gap = 0;
            else if (roll < 92) gap = $urandom_range(3, 1);
            else gap = $urandom_range(60, 10);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_mix(input int count);
        repeat (count) begin
            if ($urandom_range(99, 0) < 85) send_tick(stroke_tick());
            else send_tick(noise_tick());
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_START_POS: cfg_start  = val[LIM_W-1:0];
            REG_END_POS:   cfg_end    = val[LIM_W-1:0];
            REG_REP_TGT:   cfg_target = val[CNT_W-1:0];
            default: begin
                cfg_speed = val[CNT_W-1:0];
                drive_mag = capped_level(longint'(cfg_speed) * DRIVE_NUM / DRIVE_DEN);
            end
        endcase
    endtask

    task automatic set_stroke(input int lo, input int hi, input int speed, input int scale);
        write_reg(REG_START_POS, lo);
        write_reg(REG_END_POS, hi);
        write_reg(REG_DES_SPEED, speed);
        t_scale = scale;
    endtask

    task automatic test_directed_walk();
        write_reg(REG_REP_TGT, 32'd65535);
        write_reg(REG_DES_SPEED, 32'd5400);
        send_tick(tick(0, 1'b1, 32'd1000));
        send_tick(tick(POS_MIN, 1'b1, 32'd1000));
        send_tick(tick(POS_MAX, 1'b1, 32'd1002));
        send_tick(tick(50, 1'b0, 32'd1003));
        send_tick(tick(100, 1'b1, 32'd1001));
        send_tick(tick(17000, 1'b0, 32'd1004));
        send_tick(tick(16951, 1'b0, 32'd1005));
        send_tick(tick(16950, 1'b1, 32'hFFFF_FFFF));
        send_tick(tick(17000, 1'b0, 32'd1));
        send_tick(tick(100, 1'b0, 32'd2));
        send_tick(tick(51, 1'b1, 32'd4));
        send_tick(tick(50, 1'b0, 32'd5));
        send_tick(tick(60, 1'b1, 32'd1004));
        send_tick(tick(60, 1'b1, 32'd2004));
        send_tick(tick(60, 1'b1, 32'd3004));
        send_tick(tick(60, 1'b1, 32'd4004));
        send_tick(tick(60, 1'b1, 32'd5004));
        send_tick(tick(150, 1'b0, 32'd5005));
        send_tick(tick(150, 1'b1, 32'd6005));
        send_tick(tick(20000, 1'b0, 32'd6006));
        send_tick(tick(16000, 1'b0, 32'd6007));
        send_tick(tick(16000, 1'b0, 32'd6008));
        send_tick(tick(-5, 1'b1, 32'd9000));
        sw_ms = 32'd10000;
        settle();
    endtask

    task automatic test_crossed_limits();
        set_stroke(POS_MAX, 0, 0, 1);
        run_mix(150);
        settle();
    endtask

    task automatic test_wide_limits();
        set_stroke(0, POS_MAX, 65535, 50);
        run_mix(300);
        settle();
    endtask

    task automatic test_mid_stroke();
        set_stroke(3000, 9000, 10000, 100);
        run_mix(300);
        settle();
    endtask

    task automatic test_narrow_stroke();
        set_stroke(8000, 8100, 30000, 5);
        run_mix(250);
        settle();
    endtask

    // result side holds off while ticks keep coming
    task automatic test_output_backpressure();
        set_stroke(50, 17000, 20000, 30);
        sender_eager = 1'b1;
        burst_num   <= burst_num + 1;
        run_mix(80);
        sender_eager = 1'b0;
        run_mix(220);
        settle();
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            set_stroke($urandom_range(20000, 0), $urandom_range(20000, 0),
                       $urandom_range(65535, 0), $urandom_range(100, 1));
            run_mix(150);
            settle();
        end
    endtask

    task automatic test_done();
        int guard;
        set_stroke(50, 3000, 20000, 10);
        write_reg(REG_REP_TGT, DATA_W'(strokes_done) + 32'd2);
        guard = 0;
        while (!run_done && guard < 800) begin
            send_tick(stroke_tick());
            guard++;
        end
        run_mix(15);
        settle();
        write_reg(REG_REP_TGT, 32'd0);
        write_reg(REG_DES_SPEED, 32'd65535);
        run_mix(5);
        settle();
    endtask

    // result side stall pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (burst_seen != burst_num) begin
            burst_seen  <= burst_num;
            burst_left  <= BURST_CYCLES;
            i_out_stall <= 1'b1;
        end else if (burst_left != 0) begin
            burst_left  <= burst_left - 1;
            i_out_stall <= 1'b1;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else if ($urandom_range(2, 0) == 0) begin
            i_out_stall <= 1'b1;
            run_left    <= ($urandom_range(9, 0) == 0) ? $urandom_range(80, 20)
                                                      : $urandom_range(4, 1);
        end else begin
            i_out_stall <= 1'b0;
            run_left    <= $urandom_range(40, 1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("result with nothing pending",
                                longint'(o_out_data.repetitions), longint'(0));
            end else begin
                due_tick = expected_ticks.pop_front();
                if (o_out_data.motor_drive !== due_tick.motor_drive)
                    report_mismatch("motor_drive", longint'(o_out_data.motor_drive),
                                    longint'(due_tick.motor_drive));
                if (o_out_data.phase !== due_tick.phase)
                    report_mismatch("phase", longint'(o_out_data.phase),
                                    longint'(due_tick.phase));
                if (o_out_data.repetitions !== due_tick.repetitions)
                    report_mismatch("repetitions", longint'(o_out_data.repetitions),
                                    longint'(due_tick.repetitions));
                if (o_out_data.done_res !== due_tick.done_res)
                    report_mismatch("done_res", longint'(o_out_data.done_res),
                                    longint'(due_tick.done_res));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_ticks.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_walk();
        test_crossed_limits();
        test_wide_limits();
        test_mid_stroke();
        test_narrow_stroke();
        test_output_backpressure();
        test_random_settings();
        test_done();

        $display("%0d ticks, %0d results checked, %0d strokes, %0d velocity samples",
                 ticks_sent, results_checked, strokes_done, samples_logged);
        $display("limits crossed, clamped and narrow; drive zero to cap; done held");
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/asms_pkg.sv
rtl/asms_serial_div.sv
rtl/assistive_stroke_motor_sequencer_unit.sv
tb/testbench.sv
